FILE: design/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg: shared types and constants for the character set difference block
// Holds the command encoding, the queued command format and back-end states.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int KIND_W      = 2;
    localparam int CH_W        = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [CH_W-1:0] ch;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_TEST
    } back_state_t;

endpackage

FILE: design/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front: command intake and queue
// Accepts items, decodes the kind into a command and holds it in a short queue.
// ----------------------------------------------------------------------------
module csd_front import csd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [CH_W-1:0]   ch,
    output logic              q_valid,
    output cmd_t              q_cmd,
    input  logic              q_pop
);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              push;
    logic              pop;
    cmd_t              cmd_in;

    // Classify the incoming item.
    always_comb
    begin
        cmd_in.op = op_t'(kind);
        cmd_in.ch = ch;
    end

    assign cmd_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid   = (fill_reg != '0);
    assign q_cmd     = q_mem_reg[rd_ptr_reg];
    assign push      = cmd_valid && cmd_ready;
    assign pop       = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

FILE: design/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back: command execution
// Keeps the presence bitmaps and first-appearance lists, scans for answers and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module csd_back import csd_pkg::*;
#(
    parameter int SYMBOL_BITS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  cmd_t            q_cmd,
    output logic            q_pop,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [CH_W-1:0] out_ch,
    output logic            out_valid,
    output logic            out_last
);

    localparam int Symbols = 1 << SYMBOL_BITS;
    localparam int CntW    = SYMBOL_BITS + 1;
    localparam int PosW    = SYMBOL_BITS + 2;

    back_state_t            state_reg;
    back_state_t            state_next;

    logic [Symbols-1:0]     seen_a_reg;
    logic [Symbols-1:0]     seen_b_reg;
    logic [CntW-1:0]        count_a_reg;
    logic [CntW-1:0]        count_b_reg;
    logic [PosW-1:0]        read_pos_reg;
    logic [PosW-1:0]        pos_reg;
    logic                   found_reg;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic                   from_a_reg;

    logic [SYMBOL_BITS-1:0] order_a_mem [Symbols];
    logic [SYMBOL_BITS-1:0] order_b_mem [Symbols];
    logic [SYMBOL_BITS-1:0] rd_a_reg;
    logic [SYMBOL_BITS-1:0] rd_b_reg;

    logic                   res_valid_reg;
    logic [CH_W-1:0]        out_ch_reg;
    logic                   out_valid_reg;
    logic                   out_last_reg;

    logic [SYMBOL_BITS-1:0] sym_in;
    logic [PosW-1:0]        total;
    logic [PosW-1:0]        pos_b;
    logic                   pos_in_a;
    logic [SYMBOL_BITS-1:0] test_sym;
    logic                   qualifies;
    logic                   out_free;

    logic                   load_a_we;
    logic                   load_b_we;
    logic                   do_clear;
    logic                   scan_start;
    logic                   rd_en;
    logic                   pos_inc;
    logic                   take_first;
    logic                   emit;
    logic [CH_W-1:0]        emit_ch;
    logic                   emit_valid;
    logic                   emit_last;

    assign sym_in    = q_cmd.ch[SYMBOL_BITS-1:0];
    assign total     = PosW'(count_a_reg) + PosW'(count_b_reg);
    assign pos_b     = pos_reg - PosW'(count_a_reg);
    assign pos_in_a  = (pos_reg < PosW'(count_a_reg));
    assign test_sym  = from_a_reg ? rd_a_reg : rd_b_reg;
    assign qualifies = from_a_reg ? !seen_b_reg[test_sym] : !seen_a_reg[test_sym];
    assign out_free  = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_a_we  = 1'b0;
        load_b_we  = 1'b0;
        do_clear   = 1'b0;
        scan_start = 1'b0;
        rd_en      = 1'b0;
        pos_inc    = 1'b0;
        take_first = 1'b0;
        emit       = 1'b0;
        emit_ch    = '0;
        emit_valid = 1'b0;
        emit_last  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        OP_LOAD_A:
                        begin
                            q_pop     = 1'b1;
                            load_a_we = (sym_in != '0) && !seen_a_reg[sym_in]
                                        && !count_a_reg[SYMBOL_BITS];
                        end
                        OP_LOAD_B:
                        begin
                            q_pop     = 1'b1;
                            load_b_we = (sym_in != '0) && !seen_b_reg[sym_in]
                                        && !count_b_reg[SYMBOL_BITS];
                        end
                        OP_CLEAR:
                        begin
                            q_pop    = 1'b1;
                            do_clear = 1'b1;
                        end
                        OP_READ:
                        begin
                            // The output slot is reserved up front, so the scan
                            // never has to wait at its end.
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                scan_start = 1'b1;
                                state_next = BK_FETCH;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FETCH:
            begin
                if (pos_reg >= total)
                begin
                    emit       = 1'b1;
                    emit_valid = found_reg;
                    emit_ch    = found_reg ? CH_W'(sym_reg) : '0;
                    emit_last  = 1'b1;
                    state_next = BK_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = BK_TEST;
                end
            end
            BK_TEST:
            begin
                if (qualifies && found_reg)
                begin
                    emit       = 1'b1;
                    emit_valid = 1'b1;
                    emit_ch    = CH_W'(sym_reg);
                    emit_last  = 1'b0;
                    state_next = BK_IDLE;
                end
                else
                begin
                    take_first = qualifies;
                    pos_inc    = 1'b1;
                    state_next = BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Order lists: undefined until written, only entries below the count are read.
    always_ff @(posedge clk)
    begin
        if (load_a_we)
        begin
            order_a_mem[count_a_reg[SYMBOL_BITS-1:0]] <= sym_in;
        end
        if (rd_en)
        begin
            rd_a_reg <= order_a_mem[pos_reg[SYMBOL_BITS-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b_we)
        begin
            order_b_mem[count_b_reg[SYMBOL_BITS-1:0]] <= sym_in;
        end
        if (rd_en)
        begin
            rd_b_reg <= order_b_mem[pos_b[SYMBOL_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_a_reg    <= '0;
            seen_b_reg    <= '0;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            read_pos_reg  <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            from_a_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_clear)
            begin
                seen_a_reg   <= '0;
                seen_b_reg   <= '0;
                count_a_reg  <= '0;
                count_b_reg  <= '0;
                read_pos_reg <= '0;
            end
            if (load_a_we)
            begin
                seen_a_reg[sym_in] <= 1'b1;
                count_a_reg        <= count_a_reg + 1'b1;
            end
            if (load_b_we)
            begin
                seen_b_reg[sym_in] <= 1'b1;
                count_b_reg        <= count_b_reg + 1'b1;
            end
            if (scan_start)
            begin
                pos_reg   <= read_pos_reg;
                found_reg <= 1'b0;
            end
            if (rd_en)
            begin
                from_a_reg <= pos_in_a;
            end
            if (pos_inc)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (take_first)
            begin
                found_reg    <= 1'b1;
                read_pos_reg <= pos_reg + 1'b1;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_first)
        begin
            sym_reg <= test_sym;
        end
        if (emit)
        begin
            out_ch_reg    <= emit_ch;
            out_valid_reg <= emit_valid;
            out_last_reg  <= emit_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_ch    = out_ch_reg;
    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: design/char_set_symmetric_difference.sv
// ----------------------------------------------------------------------------
// char_set_symmetric_difference: ordered symmetric difference of two byte sets
// Loads two strings byte by byte and returns, one byte per read item, the
// bytes unique to either string in order of first appearance.
// ----------------------------------------------------------------------------
// Timing: an item leaves the two-entry queue in the cycle after it is accepted
//   at the earliest; a load or clear takes effect at the edge that removes it. A
//   read item passes through a fetch state and a test state for each list entry
//   it examines, and its result is registered when a fetch state finds the end
//   of the list or when a test state finds a second answer that stops it early.
// Throughput: one load or clear per cycle while no read runs; reads are bounded
//   by the single read port of the order memories, fetch then test per entry.
// Reset: rst_n clears both bitmaps, both counts, the read position, the queue
//   and res_valid at once; the order memories and output data are not cleared.
// ----------------------------------------------------------------------------
module char_set_symmetric_difference import csd_pkg::*;
#(
    parameter int SYMBOL_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [CH_W-1:0]   ch,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [CH_W-1:0]   out_ch,
    output logic              out_valid,
    output logic              out_last
);

    // Queue hand-off between the intake and the execution side.
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // The front end takes items whenever its queue has room, so loads can keep
    // arriving while a read is still scanning or a result waits to be taken.
    csd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .kind      (kind),
        .ch        (ch),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    // The back end carries out one command at a time. A read walks the list of
    // string one followed by string two from the saved read position, testing
    // each entry against the other string's bitmap; after the first answer it
    // keeps looking only to learn whether another answer follows.
    csd_back #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_ch    (out_ch),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

    // An answer byte is never the terminator.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> out_ch != '0)
        else $error("answer byte is zero");

    // With no answer left the byte is zero and the item is flagged last.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_ch == '0 && out_last)
        else $error("empty result not flagged correctly");

    // Answer bytes stay within the configured symbol width.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_ch >> SYMBOL_BITS) == '0)
        else $error("answer byte wider than symbol width");

endmodule

FILE: tb/sv/char_set_symmetric_difference_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_set_symmetric_difference_test: self-checking bench for the set block
// Drives load, read and clear items through the command channel, predicts
// every answer byte from a private copy of both sets and checks each result.
// ----------------------------------------------------------------------------
module char_set_symmetric_difference_test;
    import csd_pkg::*;

    // A generous bound on cycles in which work is pending but nothing moves.
    // The slowest read scans both full lists, and the receiver may stall as well.
    localparam int STALL_LIMIT = 20000;
    localparam int SYMBOLS     = 256;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            valid;
        logic            last;
    } answer_t;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ch;
    logic              res_valid;
    logic              res_ready;
    logic [CH_W-1:0]   out_ch;
    logic              out_valid;
    logic              out_last;

    // Private copy of the block's state, used to predict each answer.
    logic            in_first [SYMBOLS];
    logic            in_second[SYMBOLS];
    logic [CH_W-1:0] first_order [SYMBOLS];
    logic [CH_W-1:0] second_order[SYMBOLS];
    int              first_count;
    int              second_count;
    int              scan_pos;

    answer_t answers_due[$];

    int errors;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int stalled_cycles;

    char_set_symmetric_difference i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .kind      (kind),
        .ch        (ch),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_ch    (out_ch),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic clear_sets();
        for (int i = 0; i < SYMBOLS; i++)
        begin
            in_first[i[CH_W-1:0]]     = 1'b0;
            in_second[i[CH_W-1:0]]    = 1'b0;
            first_order[i[CH_W-1:0]]  = '0;
            second_order[i[CH_W-1:0]] = '0;
        end
        first_count  = 0;
        second_count = 0;
        scan_pos     = 0;
    endtask

    // The combined list is the first string's order followed by the second's.
    function automatic logic [CH_W-1:0] list_entry(int p);
        if (p < first_count)
            return first_order[p[CH_W-1:0]];
        return second_order[CH_W'(p - first_count)];
    endfunction

    // An entry is part of the answer when the other string lacks its byte.
    function automatic logic entry_is_unique(int p);
        if (p < first_count)
            return !in_second[first_order[p[CH_W-1:0]]];
        if (p < first_count + second_count)
            return !in_first[second_order[CH_W'(p - first_count)]];
        return 1'b0;
    endfunction

    task automatic next_answer(output answer_t a);
        int   total;
        logic found;
        total   = first_count + second_count;
        a.ch    = '0;
        a.valid = 1'b0;
        a.last  = 1'b1;
        found   = 1'b0;
        // Scanning resumes where the previous answer left off, against the
        // sets as they stand now, so earlier answers are never revisited.
        for (int p = scan_pos; p < total && !found; p++)
        begin
            if (entry_is_unique(p))
            begin
                found    = 1'b1;
                scan_pos = p + 1;
                a.ch     = list_entry(p);
                a.valid  = 1'b1;
                for (int q = p + 1; q < total; q++)
                begin
                    if (entry_is_unique(q))
                        a.last = 1'b0;
                end
            end
        end
    endtask

    // Applies one accepted item to the private sets and queues any answer.
    task automatic apply_item(op_t op, logic [CH_W-1:0] c);
        answer_t a;
        case (op)
            OP_LOAD_A:
            begin
                // The terminator byte and repeated bytes leave the set unchanged.
                if (c != '0 && !in_first[c] && first_count < SYMBOLS)
                begin
                    in_first[c]                          = 1'b1;
                    first_order[first_count[CH_W-1:0]]   = c;
                    first_count++;
                end
            end
            OP_LOAD_B:
            begin
                if (c != '0 && !in_second[c] && second_count < SYMBOLS)
                begin
                    in_second[c]                         = 1'b1;
                    second_order[second_count[CH_W-1:0]] = c;
                    second_count++;
                end
            end
            OP_READ:
            begin
                next_answer(a);
                answers_due.push_back(a);
            end
            default:
                clear_sets();
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Called and returning at a falling edge. Valid is left high after the
    // item is taken, so a following item replaces it without a low cycle.
    task automatic send_item(op_t op, logic [CH_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        kind      = op;
        ch        = c;
        do
            @(posedge clk);
        while (!cmd_ready);
        apply_item(op, c);
        items_sent++;
        @(negedge clk);
    endtask

    // The receiver decides afresh on each cycle whether to take a result.
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: result with none expected: out_ch %0h out_valid %b out_last %b",
                         $time, out_ch, out_valid, out_last);
                errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (out_ch !== want.ch)
                begin
                    $display("%0t: out_ch expected %0h actual %0h", $time, want.ch, out_ch);
                    errors++;
                end
                if (out_valid !== want.valid)
                begin
                    $display("%0t: out_valid expected %b actual %b",
                             $time, want.valid, out_valid);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
                    errors++;
                end
            end
        end
    end

    // The watchdog only counts while something is outstanding, so that
    // deliberate pauses with nothing in flight never trip it.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) ||
            (!cmd_valid && answers_due.size() == 0))
            stalled_cycles <= 0;
        else if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, stalled_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked items: extreme bytes, the terminator, repeats, an empty
    // read, loads that arrive after reads have begun, and a clear.
    task automatic test_directed();
        send_item(OP_READ,   8'h00);
        send_item(OP_LOAD_A, 8'h00);
        send_item(OP_LOAD_A, 8'hff);
        send_item(OP_LOAD_A, 8'h01);
        send_item(OP_LOAD_A, 8'hff);
        send_item(OP_LOAD_A, 8'h80);
        send_item(OP_LOAD_B, 8'h01);
        send_item(OP_LOAD_B, 8'h7f);
        send_item(OP_LOAD_B, 8'h00);
        send_item(OP_LOAD_B, 8'h7f);
        send_item(OP_READ,   8'hff);
        send_item(OP_READ,   8'h00);
        send_item(OP_READ,   8'h55);
        send_item(OP_READ,   8'haa);
        // The byte just returned now also appears in the first string; it is
        // not revised, and the next read finds nothing.
        send_item(OP_LOAD_A, 8'h7f);
        send_item(OP_READ,   8'h00);
        send_item(OP_LOAD_B, 8'h55);
        send_item(OP_READ,   8'h00);
        send_item(OP_READ,   8'h00);
        send_item(OP_CLEAR,  8'hff);
        send_item(OP_READ,   8'h00);
        send_item(OP_LOAD_B, 8'hfe);
        send_item(OP_READ,   8'h00);
        send_item(OP_CLEAR,  8'h00);
    endtask

    // Both strings hold nearly every byte, so reads scan the longest lists
    // the block can hold.
    task automatic test_full_strings();
        send_item(OP_CLEAR, 8'h00);
        for (int b = 1; b < SYMBOLS; b++)
            send_item(OP_LOAD_A, b[CH_W-1:0]);
        for (int b = SYMBOLS - 1; b > 0; b--)
        begin
            if (b != 8'h80)
                send_item(OP_LOAD_B, b[CH_W-1:0]);
        end
        repeat (3)
            send_item(OP_READ, CH_W'($urandom_range(0, 255)));
        send_item(OP_CLEAR, 8'h00);
    endtask

    // One job: usually a clear, two short strings drawn from a small random
    // alphabet so that they overlap and repeat, then a run of reads that
    // sometimes has further loads mixed in.
    task automatic random_job();
        logic [CH_W-1:0] alphabet[8];
        int              len_first;
        int              len_second;
        int              reads;
        for (int i = 0; i < 8; i++)
            alphabet[i] = ($urandom_range(0, 7) == 0) ? 8'h00
                                                      : CH_W'($urandom_range(1, 255));
        if ($urandom_range(0, 9) != 0)
            send_item(OP_CLEAR, CH_W'($urandom_range(0, 255)));
        len_first  = $urandom_range(0, 12);
        len_second = $urandom_range(0, 12);
        repeat (len_first)
            send_item(OP_LOAD_A, alphabet[$urandom_range(0, 7)]);
        repeat (len_second)
            send_item(OP_LOAD_B, alphabet[$urandom_range(0, 7)]);
        reads = $urandom_range(1, len_first + len_second + 2);
        repeat (reads)
        begin
            if ($urandom_range(0, 5) == 0)
                send_item($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                          alphabet[$urandom_range(0, 7)]);
            send_item(OP_READ, CH_W'($urandom_range(0, 255)));
        end
        // Now and then a burst of unstructured items.
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                send_item(op_t'($urandom_range(0, 3)), CH_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random(int send_pct, int recv_pct, int count);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = items_sent;
        while (items_sent - start < count)
            random_job();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        errors         = 0;
        items_sent     = 0;
        stalled_cycles = 0;
        send_idle_pct  = 20;
        recv_idle_pct  = 78;
        cmd_valid      = 1'b0;
        kind           = OP_LOAD_A;
        ch             = '0;
        rst_n          = 1'b0;
        clear_sets();
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(20, 78, 90);
        test_random(78, 20, 90);
        test_random(0, 0, 80);
        test_full_strings();

        cmd_valid = 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        // A trailing load or clear produces nothing; give the block time to
        // show any stray result.
        repeat (50)
            @(negedge clk);

        if (errors == 0 && answers_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
design/csd_pkg.sv
design/csd_front.sv
design/csd_back.sv
design/char_set_symmetric_difference.sv
tb/sv/char_set_symmetric_difference_test.sv
